### rtl/core/pfu_pkg.sv
// shared types, constants and elaboration-time helpers for the power falloff utility
// no dependencies
package pfu_pkg;

   localparam int DEF_FRACTION_BITS = 16;
   localparam int LOG_BITS          = 30;   // fraction bits of log2 and of the exp2 argument
   localparam int EXP_STEPS         = 30;   // factors in the exp2 product
   localparam int SHIFT_LIMIT       = 33;   // right shift at which the power is zero

   typedef enum logic [1:0] {
      CSR_CENTER = 2'd0,
      CSR_HALF   = 2'd1,
      CSR_SHAPE  = 2'd2,
      CSR_GAIN   = 2'd3
   } csr_index_type;

   // control bits that travel with every transaction
   typedef struct packed {
      logic valid;
      logic beyond;   // distance reached half width
      logic unity;    // power is exactly 1.0
      logic zero;     // power is exactly 0
   } pfu_ctl_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Q0.32 factor 2^(-2^-idx), idx from 1, built by a truncated square-root chain
   function automatic logic [31:0] exp_factor(input int idx);
      logic [63:0] c;
      c = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 1; j < idx; j++) begin
         c = isqrt64({c[31:0], 32'h0});
      end
      return c[31:0];
   endfunction

endpackage

### rtl/core/power_falloff_utility.sv
// top level of the power falloff utility: registers, pipeline sections, gain and output
// depends on pfu_pkg, pfu_div, pfu_log, pfu_exp
//
//  port group  direction  transaction contents
//  req_*       in         sample_value, signed integer
//  rsp_*       out        utility (signed Q8.8), beyond_width
//  csr_*       in         write of center, half width, shape exponent or gain
//
// one transaction enters per cycle while req_stall is low; FRACTION_BITS + 67 register stages
// lie between a request and its result
// (divider steps, 30 squaring stages, 30 exp2 multiplier stages and a few more)
// the whole pipeline advances together; a stalled result holds every stage,
// and req_stall rises only while a result waits under rsp_stall
// reset clears the valid bits and loads the register defaults
module power_falloff_utility #(
   parameter int FRACTION_BITS = pfu_pkg::DEF_FRACTION_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_utility,
   output logic               rsp_beyond_width,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   import pfu_pkg::*;

   localparam int AW = $clog2(FRACTION_BITS + 1) + 46;

   // configuration registers
   logic signed [15:0] center_ff;
   logic [15:0]        half_ff;
   logic [15:0]        shape_ff;
   logic signed [15:0] gain_ff;

   logic advance;

   pfu_ctl_type              div_ctl;
   logic [FRACTION_BITS-1:0] div_frac;
   pfu_ctl_type              log_ctl;
   logic [AW-1:0]            log_arg;
   pfu_ctl_type              exp_ctl;
   logic [32:0]              exp_power;

   // gain stage
   logic        g_neg;
   logic [16:0] g_mag;
   logic [49:0] g_prod;
   pfu_ctl_type mul_ctl_ff;
   logic [15:0] mul_mag_ff;
   logic        mul_neg_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_utility_ff;
   logic signed [15:0] rsp_utility_in;
   logic               rsp_beyond_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= 16'sd0;
         half_ff   <= 16'd1;
         shape_ff  <= 16'd4096;
         gain_ff   <= 16'sd256;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER: center_ff <= csr_wr_data;
            CSR_HALF:   half_ff   <= csr_wr_data;
            CSR_SHAPE:  shape_ff  <= csr_wr_data;
            CSR_GAIN:   gain_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // everything moves unless a finished result is held at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   pfu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (req_valid),
      .sample_value (req_sample_value),
      .center_value (center_ff),
      .half_width   (half_ff),
      .ctl_out      (div_ctl),
      .frac_out     (div_frac)
   );

   pfu_log #(.FRACTION_BITS(FRACTION_BITS), .AW(AW)) u_log (
      .clock          (clock),
      .reset          (reset),
      .en             (advance),
      .ctl_in         (div_ctl),
      .frac_in        (div_frac),
      .shape_exponent (shape_ff),
      .ctl_out        (log_ctl),
      .arg_out        (log_arg)
   );

   pfu_exp #(.AW(AW)) u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .ctl_in    (log_ctl),
      .arg_in    (log_arg),
      .ctl_out   (exp_ctl),
      .power_out (exp_power)
   );

   // magnitude of gain times Q1.32 power, truncated toward zero
   always_comb begin
      g_neg  = gain_ff[15];
      g_mag  = g_neg ? 17'(-{gain_ff[15], gain_ff}) : {1'b0, gain_ff};
      g_prod = 50'(g_mag) * 50'(exp_power);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
      end else if (advance) begin
         mul_ctl_ff <= exp_ctl;
      end
      if (advance) begin
         mul_mag_ff <= g_prod[47:32];
         mul_neg_ff <= g_neg;
      end
   end

   always_comb begin
      if (mul_ctl_ff.beyond) begin
         rsp_utility_in = 16'sd0;
      end else if (mul_neg_ff) begin
         rsp_utility_in = -$signed(mul_mag_ff);
      end else begin
         rsp_utility_in = $signed(mul_mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_ctl_ff.valid;
      end
      if (advance) begin
         rsp_utility_ff <= rsp_utility_in;
         rsp_beyond_ff  <= mul_ctl_ff.beyond;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_utility      = rsp_utility_ff;
   assign rsp_beyond_width = rsp_beyond_ff;

`ifndef SYNTH
   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

   // out of range results are exactly zero
   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beyond_ff |-> rsp_utility_ff == 16'sd0)
      else $error("beyond width with nonzero utility");

   // a held output freezes the pipeline contents
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(exp_ctl) && $stable(mul_ctl_ff))
      else $error("pipeline moved while output held");
`endif

endmodule

### rtl/core/pfu_div.sv
// distance, range check and fraction divider, one quotient bit per stage
// depends on pfu_pkg
module pfu_div #(
   parameter int FRACTION_BITS = pfu_pkg::DEF_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [15:0]       sample_value,
   input  logic signed [15:0]       center_value,
   input  logic [15:0]              half_width,
   output pfu_pkg::pfu_ctl_type     ctl_out,
   output logic [FRACTION_BITS-1:0] frac_out
);
   import pfu_pkg::*;

   localparam int FB = FRACTION_BITS;

   logic signed [16:0] diff;
   logic [16:0]        distance;
   logic [16:0]        hw;
   pfu_ctl_type        ctl0_in;
   logic [15:0]        rem0_in;

   pfu_ctl_type        ctl_ff [0:FB];
   logic [15:0]        rem_ff [0:FB];
   logic [FB-1:0]      q_ff   [0:FB];

   assign hw = (half_width == 16'd0) ? 17'd1 : {1'b0, half_width};

   always_comb begin
      diff = {sample_value[15], sample_value} - {center_value[15], center_value};
      distance = diff[16] ? 17'(-diff) : 17'(diff);
      ctl0_in.valid  = in_valid;
      ctl0_in.beyond = distance >= hw;
      ctl0_in.unity  = distance == 17'd0;
      ctl0_in.zero   = 1'b0;
      rem0_in        = 16'(hw - distance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl0_in;
      end
      if (en) begin
         rem_ff[0] <= rem0_in;
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 1; j <= FB; j++) begin : g_step
      logic [16:0]   rem2;
      logic          ge;
      logic [15:0]   rem_in;
      logic [FB-1:0] q_in;

      always_comb begin
         rem2   = {rem_ff[j-1], 1'b0};
         ge     = rem2 >= hw;
         rem_in = ge ? 16'(rem2 - hw) : rem2[15:0];
         q_in   = {q_ff[j-1][FB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (en) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
         if (en) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   assign ctl_out  = ctl_ff[FB];
   assign frac_out = q_ff[FB];

endmodule

### rtl/core/pfu_log.sv
// log2 of the fraction by repeated squaring, then product with the exponent
// depends on pfu_pkg
module pfu_log #(
   parameter int FRACTION_BITS = pfu_pkg::DEF_FRACTION_BITS,
   parameter int AW = $clog2(FRACTION_BITS + 1) + 46
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  pfu_pkg::pfu_ctl_type     ctl_in,
   input  logic [FRACTION_BITS-1:0] frac_in,
   input  logic [15:0]              shape_exponent,
   output pfu_pkg::pfu_ctl_type     ctl_out,
   output logic [AW-1:0]            arg_out
);
   import pfu_pkg::*;

   localparam int FB = FRACTION_BITS;
   localparam int KW = $clog2(FB);
   localparam int EW = $clog2(FB + 1);
   localparam int LW = EW + LOG_BITS;

   logic [KW-1:0] lead;
   logic [4:0]    sh;
   logic [30:0]   m0_in;
   logic [EW-1:0] ek0_in;
   pfu_ctl_type   ctl0_in;

   pfu_ctl_type   ctl_ff  [0:LOG_BITS];
   logic [30:0]   m_ff    [0:LOG_BITS];
   logic [29:0]   bits_ff [0:LOG_BITS];
   logic [EW-1:0] ek_ff   [0:LOG_BITS];

   pfu_ctl_type   ctl_l_ff;
   logic [LW-1:0] l_ff;
   logic [LW-1:0] l_in;
   pfu_ctl_type   ctl_a_ff;
   logic [AW-1:0] a_ff;
   logic [AW-1:0] a_in;

   // leading one and normalization to Q1.30
   always_comb begin
      lead = '0;
      for (int b = 0; b < FB; b++) begin
         if (frac_in[b]) begin
            lead = KW'(b);
         end
      end
      sh     = 5'(30 - int'(lead));
      m0_in  = 31'(frac_in) << sh;
      ek0_in = EW'(FB - int'(lead));
      ctl0_in       = ctl_in;
      ctl0_in.unity = ctl_in.unity | (shape_exponent == 16'd0);
      ctl0_in.zero  = frac_in == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl0_in;
      end
      if (en) begin
         m_ff[0]    <= m0_in;
         bits_ff[0] <= '0;
         ek_ff[0]   <= ek0_in;
      end
   end

   for (genvar i = 1; i <= LOG_BITS; i++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      logic [30:0] m_in;
      logic        b;

      always_comb begin
         sq   = 62'(m_ff[i-1]) * 62'(m_ff[i-1]);
         t    = 32'(sq >> 30);
         b    = t[31];
         m_in = b ? t[31:1] : t[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         if (en) begin
            m_ff[i]    <= m_in;
            bits_ff[i] <= {bits_ff[i-1][28:0], b};
            ek_ff[i]   <= ek_ff[i-1];
         end
      end
   end

   // negated log2 in Q.30, then times the Q4.12 exponent
   assign l_in = {ek_ff[LOG_BITS], 30'h0} - LW'(bits_ff[LOG_BITS]);
   assign a_in = AW'(l_ff) * AW'(shape_exponent);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_l_ff <= '0;
         ctl_a_ff <= '0;
      end else if (en) begin
         ctl_l_ff <= ctl_ff[LOG_BITS];
         ctl_a_ff <= ctl_l_ff;
      end
      if (en) begin
         l_ff <= l_in;
         a_ff <= a_in;
      end
   end

   assign ctl_out = ctl_a_ff;
   assign arg_out = a_ff;

endmodule

### rtl/core/pfu_exp.sv
// exp2 of the negated argument as a product of constant factors, then the integer shift
// depends on pfu_pkg
module pfu_exp #(
   parameter int AW = 51
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  pfu_pkg::pfu_ctl_type ctl_in,
   input  logic [AW-1:0]        arg_in,
   output pfu_pkg::pfu_ctl_type ctl_out,
   output logic [32:0]          power_out
);
   import pfu_pkg::*;

   localparam int NW = AW - 42;

   pfu_ctl_type ctl_ff [1:EXP_STEPS];
   logic [31:0] acc_ff [1:EXP_STEPS];
   logic        one_ff [1:EXP_STEPS];
   logic [29:0] r_ff   [1:EXP_STEPS];
   logic [NW-1:0] n_ff [1:EXP_STEPS];

   pfu_ctl_type ctl_p_ff;
   logic [32:0] p_ff;
   logic [32:0] p_in;
   logic [32:0] pw;

   for (genvar i = 1; i <= EXP_STEPS; i++) begin : g_mul
      localparam logic [31:0] FACTOR = exp_factor(i);
      pfu_ctl_type ctl_p;
      logic [31:0] acc_p;
      logic        one_p;
      logic [29:0] r_p;
      logic [NW-1:0] n_p;
      logic [63:0] prod;
      logic [31:0] acc_in;
      logic        one_in;

      if (i == 1) begin : g_first
         assign ctl_p = ctl_in;
         assign acc_p = '0;
         assign one_p = 1'b1;
         assign r_p   = arg_in[41:12];
         assign n_p   = arg_in[AW-1:42];
      end else begin : g_next
         assign ctl_p = ctl_ff[i-1];
         assign acc_p = acc_ff[i-1];
         assign one_p = one_ff[i-1];
         assign r_p   = r_ff[i-1];
         assign n_p   = n_ff[i-1];
      end

      always_comb begin
         prod   = 64'(acc_p) * 64'(FACTOR);
         acc_in = acc_p;
         one_in = one_p;
         if (r_p[EXP_STEPS-i]) begin
            acc_in = one_p ? FACTOR : prod[63:32];
            one_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_p;
         end
         if (en) begin
            acc_ff[i] <= acc_in;
            one_ff[i] <= one_in;
            r_ff[i]   <= r_p;
            n_ff[i]   <= n_p;
         end
      end
   end

   always_comb begin
      pw = one_ff[EXP_STEPS] ? 33'h1_0000_0000 : {1'b0, acc_ff[EXP_STEPS]};
      if (ctl_ff[EXP_STEPS].unity) begin
         p_in = 33'h1_0000_0000;
      end else if (ctl_ff[EXP_STEPS].zero || (n_ff[EXP_STEPS] >= NW'(SHIFT_LIMIT))) begin
         p_in = '0;
      end else begin
         p_in = pw >> n_ff[EXP_STEPS][5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
      end else if (en) begin
         ctl_p_ff <= ctl_ff[EXP_STEPS];
      end
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign ctl_out   = ctl_p_ff;
   assign power_out = p_ff;

endmodule
